// ===== rtl/core/c3sl_pkg.sv =====
`default_nettype none

package c3sl_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_SIZE    = 3;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 10;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 13;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 32;
    localparam int SUM_W       = 14;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = 3;
    localparam int FIFO_CNT_W  = 4;
    localparam int MAX_RESULTS = 3;

    // floor(x / 9) == (x * BOX_RECIP) >> 16 for every x below 32768.
    localparam int BOX_RECIP   = 7282;
    localparam int BOX_SHIFT   = 16;

    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;
    localparam logic [PIX_W-1:0]    RESET_OFFSET = 8'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2,
        REG_OFFSET = 2'd3
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_BOX      = 2'd0,
        MODE_WEIGHTED = 2'd1,
        MODE_LAP4     = 2'd2,
        MODE_LAP8     = 2'd3
    } t_mode;

    typedef struct packed {
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pixel;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/conv3x3_smooth_laplace_filter.sv =====
`default_nettype none
// An accepted pixel passes the stage 1 and stage 2 registers and the result queue to the output.
// Throughput: one pixel per cycle while the queue has room for three results; the output side
// moves one result per cycle, so inputs stall on the last row, where a pixel gives up to three.
// The line buffers are one 1024 x 16 memory read at the accept edge and written back next cycle.
// Synchronous active-low reset clears position, configuration, window and queue; the line
// memory is not cleared.

module conv3x3_smooth_laplace_filter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [c3sl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [c3sl_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // in_pixel [7:0]
    input  wire logic [c3sl_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // out_pixel [7:0], out_row [19:8], out_col [29:20], zero [31:30]
    output logic [c3sl_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    // last_of_run
    output logic                                    o_m_axis_tlast
);
    import c3sl_pkg::*;

    logic [WIDTH_W-1:0]    r_width;
    logic [HEIGHT_W-1:0]   r_height;
    t_mode                 r_mode;
    logic [PIX_W-1:0]      r_offset;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;

    logic [WIDTH_W-1:0]    w_eff;
    logic [HEIGHT_W-1:0]   h_eff;
    logic                  pos_wrap;
    logic [ROW_W-1:0]      cur_row;
    logic [COL_W-1:0]      cur_col;
    logic                  is_a, is_b, is_c, is_int;
    logic [1:0]            acc_n;
    logic [WIDTH_W-1:0]    col_inc;
    logic [HEIGHT_W-1:0]   row_inc;
    logic [ROW_W-1:0]      n_row;
    logic [COL_W-1:0]      n_col;
    logic                  accept;
    logic                  pop;

    logic [FIFO_CNT_W-1:0] r_used;

    always_comb begin
        if (r_width < WIDTH_W'(MIN_SIZE)) begin
            w_eff = WIDTH_W'(MIN_SIZE);
        end else if (r_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height < HEIGHT_W'(MIN_SIZE)) begin
            h_eff = HEIGHT_W'(MIN_SIZE);
        end else if (r_height > HEIGHT_W'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end

        pos_wrap = (WIDTH_W'(r_col) >= w_eff) || (HEIGHT_W'(r_row) >= h_eff);
        cur_row  = pos_wrap ? '0 : r_row;
        cur_col  = pos_wrap ? '0 : r_col;

        is_a   = (cur_row != '0) && (cur_col != '0);
        is_b   = (cur_row != '0) && (WIDTH_W'(cur_col) == w_eff - WIDTH_W'(1));
        is_c   = (HEIGHT_W'(cur_row) == h_eff - HEIGHT_W'(1));
        is_int = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
        acc_n  = 2'(is_a) + 2'(is_b) + 2'(is_c);

        col_inc = WIDTH_W'(cur_col) + WIDTH_W'(1);
        row_inc = HEIGHT_W'(cur_row) + HEIGHT_W'(1);
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = cur_row;
        end
    end

    assign o_s_axis_tready = (r_used <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
            r_mode   <= MODE_BOX;
            r_offset <= RESET_OFFSET;
            r_row    <= '0;
            r_col    <= '0;
        end else begin
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    REG_WIDTH: begin
                        r_width <= i_cfg_data[WIDTH_W-1:0];
                        r_row   <= '0;
                        r_col   <= '0;
                    end
                    REG_HEIGHT: begin
                        r_height <= i_cfg_data[HEIGHT_W-1:0];
                        r_row    <= '0;
                        r_col    <= '0;
                    end
                    REG_MODE: begin
                        r_mode <= t_mode'(i_cfg_data[MODE_W-1:0]);
                    end
                    REG_OFFSET: begin
                        r_offset <= i_cfg_data[PIX_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Line memory: upper row in the high byte, middle row in the low byte.
    logic [2*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_line_q;

    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_s1_pix;
    logic [ROW_W-1:0]   r_s1_row;
    logic [COL_W-1:0]   r_s1_col;
    logic               r_s1_a, r_s1_b, r_s1_c, r_s1_int;
    logic [PIX_W-1:0]   r_win [6];

    logic [PIX_W-1:0]   up, md;
    logic [PIX_W+1:0]   corners, edges;
    logic [SUM_W-1:0]   n_sum;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_q <= r_line_mem[cur_col];
        end
        if (r_s1_valid) begin
            r_line_mem[r_s1_col] <= {md, r_s1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_s1_pix <= i_s_axis_tdata[PIX_W-1:0];
            r_s1_row <= cur_row;
            r_s1_col <= cur_col;
            r_s1_a   <= is_a;
            r_s1_b   <= is_b;
            r_s1_c   <= is_c;
            r_s1_int <= is_int;
        end
    end

    assign up = r_line_q[2*PIX_W-1:PIX_W];
    assign md = r_line_q[PIX_W-1:0];

    always_comb begin
        corners = (PIX_W+2)'(r_win[0]) + (PIX_W+2)'(up)
                + (PIX_W+2)'(r_win[2]) + (PIX_W+2)'(r_s1_pix);
        edges   = (PIX_W+2)'(r_win[3]) + (PIX_W+2)'(r_win[1])
                + (PIX_W+2)'(md) + (PIX_W+2)'(r_win[5]);
        case (r_mode)
            MODE_BOX: begin
                n_sum = SUM_W'(corners) + SUM_W'(edges) + SUM_W'(r_win[4]);
            end
            MODE_WEIGHTED: begin
                n_sum = SUM_W'(corners) + (SUM_W'(edges) << 1) + (SUM_W'(r_win[4]) << 2);
            end
            MODE_LAP4: begin
                n_sum = (SUM_W'(r_win[4]) << 2) - SUM_W'(edges);
            end
            MODE_LAP8: begin
                n_sum = (SUM_W'(r_win[4]) << 3) - SUM_W'(corners) - SUM_W'(edges);
            end
            default: begin
                n_sum = '0;
            end
        endcase
    end

    logic               r_s2_valid;
    logic [SUM_W-1:0]   r_s2_sum;
    logic [PIX_W-1:0]   r_s2_border;
    logic [PIX_W-1:0]   r_s2_md;
    logic [PIX_W-1:0]   r_s2_pix;
    logic [ROW_W-1:0]   r_s2_row;
    logic [COL_W-1:0]   r_s2_col;
    logic               r_s2_a, r_s2_b, r_s2_c, r_s2_int;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= up;
                r_win[4] <= md;
                r_win[5] <= r_s1_pix;
            end
        end
        if (r_s1_valid) begin
            r_s2_sum    <= n_sum;
            r_s2_border <= r_win[4];
            r_s2_md     <= md;
            r_s2_pix    <= r_s1_pix;
            r_s2_row    <= r_s1_row;
            r_s2_col    <= r_s1_col;
            r_s2_a      <= r_s1_a;
            r_s2_b      <= r_s1_b;
            r_s2_c      <= r_s1_c;
            r_s2_int    <= r_s1_int;
        end
    end

    logic [24:0]      box_prod;
    logic [PIX_W-1:0] lap_clamp;
    logic [PIX_W-1:0] filt;
    t_result          res_a, res_b, res_c;
    logic [1:0]       push_n;

    always_comb begin
        box_prod = 25'(r_s2_sum[11:0]) * 25'(BOX_RECIP);
        if (r_s2_sum[SUM_W-1]) begin
            lap_clamp = '0;
        end else if (r_s2_sum > SUM_W'(255)) begin
            lap_clamp = '1;
        end else begin
            lap_clamp = r_s2_sum[PIX_W-1:0];
        end
        case (r_mode)
            MODE_BOX:      filt = box_prod[BOX_SHIFT+PIX_W-1:BOX_SHIFT];
            MODE_WEIGHTED: filt = r_s2_sum[PIX_W+3:4];
            MODE_LAP4:     filt = lap_clamp + r_offset;
            MODE_LAP8:     filt = lap_clamp + r_offset;
            default:       filt = '0;
        endcase

        res_a.pixel = r_s2_int ? filt : r_s2_border;
        res_a.row   = r_s2_row - ROW_W'(1);
        res_a.col   = r_s2_col - COL_W'(1);
        res_a.last  = !r_s2_b && !r_s2_c;
        res_b.pixel = r_s2_md;
        res_b.row   = r_s2_row - ROW_W'(1);
        res_b.col   = r_s2_col;
        res_b.last  = !r_s2_c;
        res_c.pixel = r_s2_pix;
        res_c.row   = r_s2_row;
        res_c.col   = r_s2_col;
        res_c.last  = 1'b1;

        push_n = r_s2_valid ? (2'(r_s2_a) + 2'(r_s2_b) + 2'(r_s2_c)) : 2'd0;
    end

    t_result               r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_fcnt;
    logic [FIFO_PTR_W-1:0] wr_b, wr_c;
    t_result               head;

    assign wr_b = r_wr_ptr + FIFO_PTR_W'(r_s2_a);
    assign wr_c = r_wr_ptr + FIFO_PTR_W'(r_s2_a) + FIFO_PTR_W'(r_s2_b);

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            if (r_s2_a) begin
                r_fifo[r_wr_ptr] <= res_a;
            end
            if (r_s2_b) begin
                r_fifo[wr_b] <= res_b;
            end
            if (r_s2_c) begin
                r_fifo[wr_c] <= res_c;
            end
        end
    end

    assign pop = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcnt   <= '0;
            r_used   <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(pop);
            r_fcnt   <= r_fcnt + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
            r_used   <= r_used + (accept ? FIFO_CNT_W'(acc_n) : '0) - FIFO_CNT_W'(pop);
        end
    end

    assign head            = r_fifo[r_rd_ptr];
    assign o_m_axis_tvalid = (r_fcnt != '0);
    assign o_m_axis_tdata  = {2'b00, head.col, head.row, head.pixel};
    assign o_m_axis_tlast  = head.last;

endmodule

`default_nettype wire

// ===== dv/conv3x3_smooth_laplace_filter_tb.sv =====
module conv3x3_smooth_laplace_filter_tb;
    import c3sl_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PIXELS = 350;

    typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_BRIGHT, PIX_DARK} t_pix_style;
    typedef enum {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_RARE} t_rx_style;

    class pixel_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        t_mode mode;
        logic [PIX_W-1:0] offset;
        logic [PIX_W-1:0] upper_row [MAX_WIDTH];
        logic [PIX_W-1:0] middle_row [MAX_WIDTH];
        logic [PIX_W-1:0] win [6];
        int unsigned row;
        int unsigned col;
        t_result pending_pixels [$];
        int errors;

        function void reset_state();
            width_reg = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            mode = MODE_BOX;
            offset = RESET_OFFSET;
            foreach (upper_row[i]) begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            row = 0;
            col = 0;
            pending_pixels.delete();
            errors = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_WIDTH: begin
                    width_reg = value[WIDTH_W-1:0];
                    row = 0;
                    col = 0;
                end
                REG_HEIGHT: begin
                    height_reg = value[HEIGHT_W-1:0];
                    row = 0;
                    col = 0;
                end
                REG_MODE: mode = t_mode'(value[MODE_W-1:0]);
                default: offset = value[PIX_W-1:0];
            endcase
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            return (v < MIN_SIZE) ? MIN_SIZE : ((v > hi) ? hi : v);
        endfunction

        function logic [PIX_W-1:0] convolve(logic [PIX_W-1:0] px [9]);
            int taps [4][9];
            int acc;
            taps = '{'{1, 1, 1, 1, 1, 1, 1, 1, 1},
                     '{1, 2, 1, 2, 4, 2, 1, 2, 1},
                     '{0, -1, 0, -1, 4, -1, 0, -1, 0},
                     '{-1, -1, -1, -1, 8, -1, -1, -1, -1}};
            acc = 0;
            for (int i = 0; i < 9; i++) acc += int'(px[i]) * taps[int'(mode)][i];
            case (mode)
                MODE_BOX: acc = acc / 9;
                MODE_WEIGHTED: acc = acc / 16;
                default: ;
            endcase
            if (acc < 0) acc = 0;
            if (acc > 255) acc = 255;
            if (mode == MODE_LAP4 || mode == MODE_LAP8) acc = acc + int'(offset);
            return acc[PIX_W-1:0];
        endfunction

        function t_result make_result(logic [PIX_W-1:0] pix, int unsigned r, int unsigned c);
            t_result res;
            res.pixel = pix;
            res.row = r[ROW_W-1:0];
            res.col = c[COL_W-1:0];
            res.last = 1'b0;
            return res;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            logic [PIX_W-1:0] up;
            logic [PIX_W-1:0] md;
            logic [PIX_W-1:0] px [9];
            t_result found [MAX_RESULTS];
            int n;
            w = clamp_size(width_reg, MAX_WIDTH);
            h = clamp_size(height_reg, MAX_HEIGHT);
            r = row;
            c = col;
            n = 0;
            if (c >= w || r >= h) begin
                r = 0;
                c = 0;
            end
            up = upper_row[c];
            md = middle_row[c];
            upper_row[c] = md;
            middle_row[c] = pix;
            if (r >= 1 && c >= 1) begin
                if (r >= 2 && c >= 2) begin
                    px = '{win[0], win[3], up, win[1], win[4], md, win[2], win[5], pix};
                    found[n] = make_result(convolve(px), r - 1, c - 1);
                end else begin
                    found[n] = make_result(win[4], r - 1, c - 1);
                end
                n++;
            end
            if (r >= 1 && c == w - 1) begin
                found[n] = make_result(md, r - 1, c);
                n++;
            end
            if (r == h - 1) begin
                found[n] = make_result(pix, r, c);
                n++;
            end
            if (n > 0) found[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) pending_pixels.push_back(found[i]);
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = up;
            win[4] = md;
            win[5] = pix;
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            row = r;
            col = c;
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
            t_result want;
            if (pending_pixels.size() == 0) begin
                $error("unexpected output transaction: tdata %h tlast %b", data, last);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            compare("out_pixel", want.pixel, data[PIX_W-1:0]);
            compare("out_row", want.row, data[PIX_W+ROW_W-1:PIX_W]);
            compare("out_col", want.col, data[PIX_W+ROW_W+COL_W-1:PIX_W+ROW_W]);
            compare("pad", '0, data[OUT_DATA_W-1:PIX_W+ROW_W+COL_W]);
            compare("last_of_run", want.last, last);
        endfunction

        function int outstanding();
            return pending_pixels.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // in_pixel [7:0]
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // out_pixel [7:0], out_row [19:8], out_col [29:20], zero [31:30]
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // last_of_run
    logic                  o_m_axis_tlast;

    pixel_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int burst_left = 0;
    logic rx_hold_req = 1'b0;
    logic rx_hold_done = 1'b0;
    int rx_hold_left = 0;
    int rx_style_left = 0;
    t_rx_style rx_style = RX_ALWAYS;

    conv3x3_smooth_laplace_filter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1) begin
            sb.check_result(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_req && !rx_hold_done) begin
            rx_hold_left = LONG_HOLD;
            rx_hold_done = 1'b1;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_axis_tready = 1'b0;
        end else begin
            if (rx_style_left == 0) begin
                rx_style = t_rx_style'($urandom_range(0, 3));
                rx_style_left = $urandom_range(4, 64);
            end
            rx_style_left--;
            case (rx_style)
                RX_ALWAYS: i_m_axis_tready = 1'b1;
                RX_HALF: i_m_axis_tready = $urandom_range(0, 1);
                RX_MOSTLY: i_m_axis_tready = ($urandom_range(0, 3) != 0);
                default: i_m_axis_tready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic logic [PIX_W-1:0] random_pixel(t_pix_style style);
        case (style)
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PIX_BRIGHT: return ($urandom_range(0, 7) == 0) ? 8'h00 : PIX_W'($urandom_range(224, 255));
            PIX_DARK: return PIX_W'($urandom_range(0, 15));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value[CFG_W-1:0];
        @(posedge i_clk);
        sb.set_register(idx, value[CFG_W-1:0]);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] pix);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(40, 120);
            end else begin
                i_s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = pix;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        sb.note_pixel(pix);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_pixels(int unsigned count, t_pix_style style);
        repeat (count) send_pixel(random_pixel(style));
    endtask

    task automatic settle();
        i_s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned w_reg;
        int unsigned h_reg;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned count;
        int unsigned random_sent;
        logic [PIX_W-1:0] dir_frame [9];
        sb.reset_state();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A single bright spike and a single dark hole push the Laplacian sums
        // past both clamp limits, and an offset of 255 wraps the clamped high result.
        write_reg(REG_WIDTH, MIN_SIZE);
        write_reg(REG_HEIGHT, MIN_SIZE);
        write_reg(REG_MODE, MODE_LAP8);
        write_reg(REG_OFFSET, 255);
        dir_frame = '{0, 0, 0, 0, 255, 0, 0, 0, 0};
        foreach (dir_frame[i]) send_pixel(dir_frame[i]);
        settle();
        write_reg(REG_MODE, MODE_LAP4);
        write_reg(REG_OFFSET, 0);
        dir_frame = '{255, 255, 255, 255, 0, 255, 255, 255, 255};
        foreach (dir_frame[i]) send_pixel(dir_frame[i]);

        // The output side holds off for a long stretch so that the block fills.
        settle();
        write_reg(REG_WIDTH, 8);
        write_reg(REG_HEIGHT, 6);
        write_reg(REG_MODE, MODE_LAP8);
        write_reg(REG_OFFSET, $urandom_range(0, 255));
        rx_hold_req = 1'b1;
        send_pixels(96, PIX_UNIFORM);
        random_sent = 96;

        w_reg = 8;
        h_reg = 6;
        while (random_sent < RANDOM_PIXELS) begin
            settle();
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0: w_reg = $urandom_range(0, MIN_SIZE - 1);
                    1: w_reg = $urandom_range(11, 40);
                    default: w_reg = $urandom_range(MIN_SIZE, 10);
                endcase
                if ($urandom_range(0, 7) == 0) h_reg = $urandom_range(0, MIN_SIZE - 1);
                else h_reg = $urandom_range(MIN_SIZE, 6);
                write_reg(REG_WIDTH, w_reg);
                write_reg(REG_HEIGHT, h_reg);
            end
            write_reg(REG_MODE, $urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: write_reg(REG_OFFSET, 0);
                1: write_reg(REG_OFFSET, 255);
                default: write_reg(REG_OFFSET, $urandom_range(0, 255));
            endcase
            w_eff = (w_reg < MIN_SIZE) ? MIN_SIZE : w_reg;
            h_eff = (h_reg < MIN_SIZE) ? MIN_SIZE : h_reg;
            count = w_eff * h_eff * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0) count += $urandom_range(1, w_eff * h_eff - 1);
            if (count > RANDOM_PIXELS - random_sent) count = RANDOM_PIXELS - random_sent;
            send_pixels(count, t_pix_style'($urandom_range(0, 3)));
            random_sent += count;
        end

        i_s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
